[src/acep_pkg.sv]
// ----------------------------------------------------------------------------
// acep_pkg: shared definitions for the ANSI color escape parser
// Character codes, SGR code bases, parser state types, result records and
// the 16-entry color palette.
// ----------------------------------------------------------------------------
package acep_pkg;

  // Longest control sequence body before it is cut off.
  localparam int MAX_SEQ_CHARS = 15;
  localparam int SEQ_CNT_W     = 4;

  // Result queue between the parser and the output port.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam logic [7:0] CODE_FG_DARK   = 8'd30;
  localparam logic [7:0] CODE_BG_DARK   = 8'd40;
  localparam logic [7:0] CODE_FG_BRIGHT = 8'd90;
  localparam logic [7:0] CODE_BG_BRIGHT = 8'd100;
  localparam logic [7:0] CODE_SPAN      = 8'd8;

  localparam logic [23:0] FG_RESET = 24'hFFFFFF;
  localparam logic [23:0] BG_RESET = 24'h000000;

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESC     = 2'd1,
    MODE_SEQ     = 2'd2,
    MODE_SWALLOW = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [23:0] fg;
    logic [23:0] bg;
    logic        last;
  } result_t;

  // Results produced by one input byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] level;
    logic                  room;
  } fifo_status_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

[src/acep_step.sv]
// ----------------------------------------------------------------------------
// acep_step: parser state and per-byte update
// Holds the escape parser state and computes the results of one byte.
// ----------------------------------------------------------------------------
module acep_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output acep_pkg::step_out_t  results
);

  acep_pkg::mode_t                   mode, mode_next;
  acep_pkg::phase_t                  phase, phase_next;
  logic [acep_pkg::SEQ_CNT_W-1:0]    seq_count, seq_count_next;
  logic [7:0]                        token_value, token_value_next;
  logic                              token_negative, token_negative_next;
  logic                              token_nonempty, token_nonempty_next;
  logic [23:0]                       foreground, foreground_next;
  logic [23:0]                       background, background_next;

  logic        is_digit, is_space, is_sign;
  logic        do_finish, do_feed;
  logic [1:0]  n;
  logic        k0;
  logic [7:0]  ch0, ch1;
  logic [11:0] prod;
  logic [7:0]  off_fd, off_bd, off_fb, off_bb;

  assign is_digit = (text_byte >= acep_pkg::CH_ZERO) && (text_byte <= acep_pkg::CH_NINE);
  assign is_space = (text_byte == acep_pkg::CH_SPACE) ||
                    ((text_byte >= acep_pkg::CH_TAB) && (text_byte <= acep_pkg::CH_CR));
  assign is_sign  = (text_byte == acep_pkg::CH_PLUS) || (text_byte == acep_pkg::CH_MINUS);

  // Digits 0x30..0x39 carry their value in the low nibble.
  assign prod = (12'(token_value) * 12'd10) + {8'd0, text_byte[3:0]};

  assign off_fd = token_value - acep_pkg::CODE_FG_DARK;
  assign off_bd = token_value - acep_pkg::CODE_BG_DARK;
  assign off_fb = token_value - acep_pkg::CODE_FG_BRIGHT;
  assign off_bb = token_value - acep_pkg::CODE_BG_BRIGHT;

  always_comb begin
    mode_next           = mode;
    phase_next          = phase;
    seq_count_next      = seq_count;
    token_value_next    = token_value;
    token_negative_next = token_negative;
    token_nonempty_next = token_nonempty;
    foreground_next     = foreground;
    background_next     = background;
    n         = 2'd0;
    k0        = acep_pkg::KIND_CHAR;
    ch0       = 8'd0;
    ch1       = 8'd0;
    do_finish = 1'b0;
    do_feed   = 1'b0;

    case (mode)
      acep_pkg::MODE_NORMAL: begin
        if (text_byte == acep_pkg::CH_ESC && !end_of_text) begin
          mode_next = acep_pkg::MODE_ESC;
        end else begin
          n   = 2'd1;
          ch0 = text_byte;
        end
      end
      acep_pkg::MODE_ESC: begin
        if (text_byte == acep_pkg::CH_LBRACKET) begin
          mode_next           = acep_pkg::MODE_SEQ;
          seq_count_next      = '0;
          token_value_next    = 8'd0;
          token_negative_next = 1'b0;
          token_nonempty_next = 1'b0;
          phase_next          = acep_pkg::PH_SPACE;
        end else begin
          // The held ESC goes out as a character, then this byte is plain text.
          n         = 2'd1;
          ch0       = acep_pkg::CH_ESC;
          mode_next = acep_pkg::MODE_NORMAL;
          if (text_byte == acep_pkg::CH_ESC && !end_of_text) begin
            mode_next = acep_pkg::MODE_ESC;
          end else begin
            n   = 2'd2;
            ch1 = text_byte;
          end
        end
      end
      acep_pkg::MODE_SEQ: begin
        if (text_byte == acep_pkg::CH_M) begin
          do_finish = 1'b1;
          mode_next = acep_pkg::MODE_NORMAL;
        end else if (!end_of_text) begin
          if (text_byte == acep_pkg::CH_SEMI) begin
            do_finish = 1'b1;
          end else begin
            do_feed = 1'b1;
          end
          seq_count_next = seq_count + 1'b1;
          if (seq_count_next >= acep_pkg::SEQ_CNT_W'(acep_pkg::MAX_SEQ_CHARS)) begin
            mode_next = acep_pkg::MODE_SWALLOW;
          end
        end
      end
      acep_pkg::MODE_SWALLOW: begin
        do_finish = 1'b1;
        mode_next = acep_pkg::MODE_NORMAL;
      end
      default: begin
        mode_next = acep_pkg::MODE_NORMAL;
      end
    endcase

    if (do_finish) begin
      if (token_nonempty) begin
        if (token_negative && token_value != 8'd0) begin
          n = 2'd0;
        end else if (token_value == 8'd0) begin
          foreground_next = acep_pkg::FG_RESET;
          background_next = acep_pkg::BG_RESET;
          n  = 2'd1;
          k0 = acep_pkg::KIND_COLOR;
        end else if (off_fd < acep_pkg::CODE_SPAN) begin
          foreground_next = acep_pkg::palette({1'b0, off_fd[2:0]});
          n  = 2'd1;
          k0 = acep_pkg::KIND_COLOR;
        end else if (off_bd < acep_pkg::CODE_SPAN) begin
          background_next = acep_pkg::palette({1'b0, off_bd[2:0]});
          n  = 2'd1;
          k0 = acep_pkg::KIND_COLOR;
        end else if (off_fb < acep_pkg::CODE_SPAN) begin
          foreground_next = acep_pkg::palette({1'b1, off_fb[2:0]});
          n  = 2'd1;
          k0 = acep_pkg::KIND_COLOR;
        end else if (off_bb < acep_pkg::CODE_SPAN) begin
          background_next = acep_pkg::palette({1'b1, off_bb[2:0]});
          n  = 2'd1;
          k0 = acep_pkg::KIND_COLOR;
        end
      end
      token_value_next    = 8'd0;
      token_negative_next = 1'b0;
      token_nonempty_next = 1'b0;
      phase_next          = acep_pkg::PH_SPACE;
    end

    if (do_feed) begin
      token_nonempty_next = 1'b1;
      if (phase == acep_pkg::PH_SPACE && is_space) begin
        phase_next = phase;
      end else if (phase == acep_pkg::PH_SPACE && is_sign) begin
        token_negative_next = (text_byte == acep_pkg::CH_MINUS);
        phase_next          = acep_pkg::PH_SIGNED;
      end else if (phase != acep_pkg::PH_DONE && is_digit) begin
        token_value_next = (prod > 12'd255) ? 8'hFF : prod[7:0];
        phase_next       = acep_pkg::PH_DIGITS;
      end else begin
        phase_next = acep_pkg::PH_DONE;
      end
    end

    if (end_of_text) begin
      mode_next           = acep_pkg::MODE_NORMAL;
      seq_count_next      = '0;
      token_value_next    = 8'd0;
      token_negative_next = 1'b0;
      token_nonempty_next = 1'b0;
      phase_next          = acep_pkg::PH_SPACE;
    end
  end

  always_comb begin
    results.count   = n;
    results.r0.kind = k0;
    results.r0.ch   = ch0;
    results.r0.fg   = foreground_next;
    results.r0.bg   = background_next;
    results.r0.last = (n == 2'd1);
    results.r1.kind = acep_pkg::KIND_CHAR;
    results.r1.ch   = ch1;
    results.r1.fg   = foreground_next;
    results.r1.bg   = background_next;
    results.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= acep_pkg::MODE_NORMAL;
      phase          <= acep_pkg::PH_SPACE;
      seq_count      <= '0;
      token_value    <= 8'd0;
      token_negative <= 1'b0;
      token_nonempty <= 1'b0;
      foreground     <= acep_pkg::FG_RESET;
      background     <= acep_pkg::BG_RESET;
    end else if (fire) begin
      mode           <= mode_next;
      phase          <= phase_next;
      seq_count      <= seq_count_next;
      token_value    <= token_value_next;
      token_negative <= token_negative_next;
      token_nonempty <= token_nonempty_next;
      foreground     <= foreground_next;
      background     <= background_next;
    end
  end

endmodule

[src/acep_fifo.sv]
// ----------------------------------------------------------------------------
// acep_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module acep_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  acep_pkg::step_out_t     push,
  input  logic                    pop_ready,
  output logic                    pop_valid,
  output acep_pkg::result_t       pop_data,
  output acep_pkg::fifo_status_t  status
);

  acep_pkg::result_t mem [acep_pkg::FIFO_DEPTH];

  logic [acep_pkg::FIFO_PTR_W-1:0] wr_ptr, wr_ptr_next, wr_ptr_plus1;
  logic [acep_pkg::FIFO_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [acep_pkg::FIFO_CNT_W-1:0] level, level_next;
  logic                            pop;

  function automatic logic [acep_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [acep_pkg::FIFO_PTR_W-1:0] p
  );
    logic [acep_pkg::FIFO_PTR_W-1:0] r;
    if (p == acep_pkg::FIFO_PTR_W'(acep_pkg::FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign pop          = pop_valid && pop_ready;
  assign pop_valid    = (level != '0);
  assign pop_data     = mem[rd_ptr];
  assign wr_ptr_plus1 = ptr_inc(wr_ptr);

  always_comb begin
    case (push.count)
      2'd1:    wr_ptr_next = wr_ptr_plus1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    level_next  = level + acep_pkg::FIFO_CNT_W'(push.count) -
                  acep_pkg::FIFO_CNT_W'(pop);
  end

  // Room for a two-result byte without counting on this cycle's pop.
  assign status.level = level;
  assign status.room  = (level <= acep_pkg::FIFO_CNT_W'(acep_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.r1;
    end
  end

endmodule

[src/ansi_color_escape_parser.sv]
// ----------------------------------------------------------------------------
// ansi_color_escape_parser: ANSI SGR color escape parser
// Passes text bytes through and turns ESC '[' ... 'm' color sequences into
// color change events carrying the current foreground and background.
// ----------------------------------------------------------------------------
// Path: a byte held in the input register is parsed once the result queue has
// room, and its results enter the queue, whose head drives the master side.
// Throughput: one byte per cycle while each byte yields at most one result and
// the master side keeps accepting; both results of a byte enter the queue together.
// The rate is set by the single parser state register and the result queue.
// Reset (rst, synchronous, active high) returns the parser to plain text,
// sets the colors to white on black and empties the result queue at once.
// ----------------------------------------------------------------------------
module ansi_color_escape_parser (
  input  logic        clk,
  input  logic        rst,
  // Slave side: one text byte per request.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  // Master side: one character or color event per request.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] char_out, [31:8] fg_color, [55:32] bg_color
  output logic        m_tuser,   // event_kind
  output logic        m_tlast    // last_of_run
);

  // Input register. It is the only stage ahead of the parser; a byte sits
  // here until the result queue has room for the two results it may cause.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eot;
  logic       s1_go;

  acep_pkg::step_out_t    step_res;
  acep_pkg::step_out_t    push;
  acep_pkg::fifo_status_t fifo_status;
  acep_pkg::result_t      head;

  assign s1_go    = s1_valid && fifo_status.room;
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
      s1_eot  <= s_tlast;
    end
  end

  // The parser commits its state update in the same cycle that its results
  // enter the queue, so results never outrun or lag the state they report.
  acep_step u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_go),
    .text_byte   (s1_byte),
    .end_of_text (s1_eot),
    .results     (step_res)
  );

  always_comb begin
    push       = step_res;
    push.count = s1_go ? step_res.count : 2'd0;
  end

  acep_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_ready (m_tready),
    .pop_valid (m_tvalid),
    .pop_data  (head),
    .status    (fifo_status)
  );

  assign m_tdata = {head.bg, head.fg, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.level <= acep_pkg::FIFO_CNT_W'(acep_pkg::FIFO_DEPTH))
    else $error("result queue level exceeds its depth");

  // A two-result byte marks only its second result as the last one.
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (s1_go && step_res.count == 2'd2) |-> (!step_res.r0.last && step_res.r1.last))
    else $error("two-result byte marks the wrong result as last");

  // A byte is pushed into the queue only when two free slots are known.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (fifo_status.level <=
      acep_pkg::FIFO_CNT_W'(acep_pkg::FIFO_DEPTH - 2)))
    else $error("results pushed without room in the queue");

  // The slave side stalls only while a byte waits in the input register, and
  // that byte stays in place across the stalled edge.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid ##1 $stable(s1_byte)))
    else $error("slave side stalled without a held byte");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ANSI color escape parser
// Streams text bytes into the parser and predicts every character and color
// event it should emit. Each result is compared field by field with the
// oldest prediction. Both stream sides idle at random, and the output side
// holds off once for a long stretch so that the parser fills up and stalls.
// ----------------------------------------------------------------------------
module tb;

  // Longest output hold-off used to back the parser up against its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles with no accepted request on either side before the run is abandoned.
  localparam int STALL_LIMIT = 4000;
  // Cycles allowed after the last prediction is matched.
  localparam int TAIL_CYCLES = 8;

  // How end_of_text is attached to the bytes of one queued string.
  typedef enum int {
    EOT_NONE,
    EOT_LAST,
    EOT_RANDOM
  } eot_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
  logic        s_tlast = 1'b0;    // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // [7:0] char_out, [31:8] fg_color, [55:32] bg_color
  logic        m_tuser;           // event_kind
  logic        m_tlast;           // last_of_run

  ansi_color_escape_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  // Results the parser still owes us, oldest first.
  acep_pkg::result_t pending_events[$];
  // Bytes queued by a test task and not yet sent.
  logic [7:0]  text_q[$];

  // When set, both sides draw a random wait before each request.
  bit          idle_en = 1'b1;
  // Set by the pressure test; the receiver clears it once its hold is over.
  bit          hold_req = 1'b0;

  int          bytes_sent = 0;
  int          results_checked = 0;
  int          color_events = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  acep_pkg::result_t head_evt;

  // --------------------------------------------------------------------------
  // Predictor: a private copy of the parser state, stepped once per accepted
  // byte. It fills step_res with the zero, one or two results of that byte.
  // --------------------------------------------------------------------------
  acep_pkg::mode_t   pmode = acep_pkg::MODE_NORMAL;
  logic [3:0]        pcount = '0;
  logic [7:0]        tok_val = '0;
  logic              tok_neg = 1'b0;
  logic              tok_any = 1'b0;
  acep_pkg::phase_t  tok_phase = acep_pkg::PH_SPACE;
  logic [23:0]       cur_fg = acep_pkg::FG_RESET;
  logic [23:0]       cur_bg = acep_pkg::BG_RESET;
  acep_pkg::result_t step_res[2];
  int                step_n;

  // The 16 text-mode colors follow a regular pattern: bit 3 selects the bright
  // half (channels 55/FF instead of 00/AA), bits 2..0 switch red, green and
  // blue. Color 6 is the usual exception, brown, whose green is only 55.
  function automatic logic [23:0] cga_rgb(input logic [3:0] idx);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    lo = idx[3] ? 8'h55 : 8'h00;
    hi = idx[3] ? 8'hFF : 8'hAA;
    r  = idx[2] ? hi : lo;
    g  = idx[1] ? hi : lo;
    b  = idx[0] ? hi : lo;
    if (idx == 4'd6) begin
      g = 8'h55;
    end
    return {r, g, b};
  endfunction

  function automatic void tok_clear();
    tok_val   = '0;
    tok_neg   = 1'b0;
    tok_any   = 1'b0;
    tok_phase = acep_pkg::PH_SPACE;
  endfunction

  // A result always carries the colors as they stand when it is produced.
  function automatic void add_result(input logic kind, input logic [7:0] ch);
    step_res[step_n] = '{kind: kind, ch: ch, fg: cur_fg, bg: cur_bg, last: 1'b0};
    step_n++;
  endfunction

  // One byte of a token, read the way atoi reads it: whitespace, then an
  // optional sign, then digits up to the first non-digit. Saturates at 255.
  function automatic void tok_feed(input logic [7:0] b);
    logic        is_digit;
    logic        is_space;
    logic [11:0] acc;
    is_digit = (b >= acep_pkg::CH_ZERO) && (b <= acep_pkg::CH_NINE);
    is_space = (b == acep_pkg::CH_SPACE) ||
               ((b >= acep_pkg::CH_TAB) && (b <= acep_pkg::CH_CR));
    tok_any  = 1'b1;
    if (tok_phase == acep_pkg::PH_SPACE) begin
      if (is_space) begin
        return;
      end
      if (b == acep_pkg::CH_PLUS || b == acep_pkg::CH_MINUS) begin
        tok_neg   = (b == acep_pkg::CH_MINUS);
        tok_phase = acep_pkg::PH_SIGNED;
        return;
      end
    end
    if (tok_phase != acep_pkg::PH_DONE && is_digit) begin
      acc       = {4'b0, tok_val} * 12'd10 + {4'b0, b - acep_pkg::CH_ZERO};
      tok_val   = (acc > 12'd255) ? 8'd255 : acc[7:0];
      tok_phase = acep_pkg::PH_DIGITS;
    end else begin
      tok_phase = acep_pkg::PH_DONE;
    end
  endfunction

  // Applies the collected token. Empty tokens vanish, negative nonzero codes
  // and codes outside the color ranges are ignored without an event.
  function automatic void tok_apply();
    logic hit;
    hit = 1'b1;
    if (tok_any) begin
      if (tok_neg && tok_val != 8'd0) begin
        hit = 1'b0;
      end else if (tok_val == 8'd0) begin
        cur_fg = acep_pkg::FG_RESET;
        cur_bg = acep_pkg::BG_RESET;
      end else if (tok_val >= acep_pkg::CODE_FG_DARK &&
                   tok_val < acep_pkg::CODE_FG_DARK + acep_pkg::CODE_SPAN) begin
        cur_fg = cga_rgb(4'(tok_val - acep_pkg::CODE_FG_DARK));
      end else if (tok_val >= acep_pkg::CODE_BG_DARK &&
                   tok_val < acep_pkg::CODE_BG_DARK + acep_pkg::CODE_SPAN) begin
        cur_bg = cga_rgb(4'(tok_val - acep_pkg::CODE_BG_DARK));
      end else if (tok_val >= acep_pkg::CODE_FG_BRIGHT &&
                   tok_val < acep_pkg::CODE_FG_BRIGHT + acep_pkg::CODE_SPAN) begin
        cur_fg = cga_rgb(4'(tok_val - acep_pkg::CODE_FG_BRIGHT + 8'd8));
      end else if (tok_val >= acep_pkg::CODE_BG_BRIGHT &&
                   tok_val < acep_pkg::CODE_BG_BRIGHT + acep_pkg::CODE_SPAN) begin
        cur_bg = cga_rgb(4'(tok_val - acep_pkg::CODE_BG_BRIGHT + 8'd8));
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        add_result(acep_pkg::KIND_COLOR, 8'h00);
      end
    end
    tok_clear();
  endfunction

  // Plain text: an ESC opens escape mode unless the string ends on it.
  function automatic void text_char(input logic [7:0] b, input logic eot);
    if (b == acep_pkg::CH_ESC && !eot) begin
      pmode = acep_pkg::MODE_ESC;
    end else begin
      add_result(acep_pkg::KIND_CHAR, b);
    end
  endfunction

  // Steps the predictor by one accepted byte and queues what it must emit.
  function automatic void parse_byte(input logic [7:0] b, input logic eot);
    step_n = 0;
    case (pmode)
      acep_pkg::MODE_NORMAL: begin
        text_char(b, eot);
      end
      acep_pkg::MODE_ESC: begin
        if (b == acep_pkg::CH_LBRACKET) begin
          pmode  = acep_pkg::MODE_SEQ;
          pcount = '0;
          tok_clear();
        end else begin
          // A lone ESC is printed, and the byte after it is plain text again.
          add_result(acep_pkg::KIND_CHAR, acep_pkg::CH_ESC);
          pmode = acep_pkg::MODE_NORMAL;
          text_char(b, eot);
        end
      end
      acep_pkg::MODE_SEQ: begin
        if (b == acep_pkg::CH_M) begin
          tok_apply();
          pmode = acep_pkg::MODE_NORMAL;
        end else if (!eot) begin
          if (b == acep_pkg::CH_SEMI) begin
            tok_apply();
          end else begin
            tok_feed(b);
          end
          pcount = pcount + 4'd1;
          if (pcount >= acep_pkg::MAX_SEQ_CHARS) begin
            pmode = acep_pkg::MODE_SWALLOW;
          end
        end
      end
      default: begin
        // The byte after a cut-off sequence is eaten but still closes it.
        tok_apply();
        pmode = acep_pkg::MODE_NORMAL;
      end
    endcase
    if (eot) begin
      pmode  = acep_pkg::MODE_NORMAL;
      pcount = '0;
      tok_clear();
    end
    if (step_n > 0) begin
      step_res[step_n-1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      pending_events.push_back(step_res[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one byte and holds it until the parser takes the request.
  // The prediction is made at the accepting edge, well before the result can
  // appear on the master side.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do begin
      @(posedge clk);
    end while (s_tready !== 1'b1);
    parse_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  task automatic put_number(input int v, input bit lead_zero);
    if (lead_zero) begin
      put_byte(acep_pkg::CH_ZERO);
    end
    put_str($sformatf("%0d", v));
  endtask

  // Sends everything queued in text_q, marking end_of_text as asked.
  task automatic send_text(input eot_mode_t mode);
    logic eot;
    for (int i = 0; i < text_q.size(); i++) begin
      case (mode)
        EOT_LAST:   eot = (i == text_q.size() - 1);
        EOT_RANDOM: eot = ((i == text_q.size() - 1) && $urandom_range(0, 3) == 0) ||
                          ($urandom_range(0, 59) == 0);
        default:    eot = 1'b0;
      endcase
      send_byte(text_q[i], eot);
    end
    text_q.delete();
  endtask

  // Lets the parser empty out: every prediction matched, then a short tail.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: draws a wait before each result request. A pending hold request
  // is folded into the wait, and it also breaks an idle wait for a result so
  // that the hold starts even when nothing is coming out yet.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    bit holding;
    bit took;
    wait (rst == 1'b0);
    forever begin
      holding = hold_req;
      gap = idle_en ? $urandom_range(0, 5) : 0;
      if (holding) begin
        gap = gap + HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (holding) begin
        hold_req = 1'b0;
      end
      m_tready <= 1'b1;
      do begin
        @(posedge clk);
        took = (m_tvalid === 1'b1);
      end while (!took && !hold_req);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted result request is matched against the oldest
  // prediction, one field at a time.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    mismatches++;
    $display("[%0t] mismatch on result %0d: %s got %h expected %h",
             $realtime, results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with nothing expected", 24'(m_tdata[7:0]), 24'h0);
      end else begin
        head_evt = pending_events.pop_front();
        if (m_tuser !== head_evt.kind) begin
          report_mismatch("event_kind", 24'(m_tuser), 24'(head_evt.kind));
        end
        if (m_tdata[7:0] !== head_evt.ch) begin
          report_mismatch("char_out", 24'(m_tdata[7:0]), 24'(head_evt.ch));
        end
        if (m_tdata[31:8] !== head_evt.fg) begin
          report_mismatch("fg_color", m_tdata[31:8], head_evt.fg);
        end
        if (m_tdata[55:32] !== head_evt.bg) begin
          report_mismatch("bg_color", m_tdata[55:32], head_evt.bg);
        end
        if (m_tlast !== head_evt.last) begin
          report_mismatch("last_of_run", 24'(m_tlast), 24'(head_evt.last));
        end
        if (head_evt.kind == acep_pkg::KIND_COLOR) begin
          color_events++;
        end
      end
      results_checked++;
    end
  end

  // Watchdog: counts cycles in which neither side accepts a request.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles, %0d results still owed",
                 STALL_LIMIT, pending_events.size());
        $display("FAIL ansi_color_escape_parser");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------
  // Byte extremes pass straight through; the zero byte is an ordinary char.
  task automatic test_plain_bytes();
    put_byte(8'h00);
    put_str("A");
    put_byte(8'hFF);
    send_text(EOT_LAST);
  endtask

  // Bright foreground, an empty token, a negative code, a non-numeric token
  // that resets, and a dark background. Then "-0" and a bare sign both reset,
  // and an oversized number saturates to a code that matches nothing.
  task automatic test_color_tokens();
    put_byte(acep_pkg::CH_ESC);
    put_str("[97;;-5;x;40m");
    put_byte(acep_pkg::CH_ESC);
    put_str("[-0;+;999m");
    send_text(EOT_NONE);
  endtask

  // ESC ESC '[' prints one ESC and opens a sequence; ESC 'Z' prints both.
  task automatic test_lone_escape();
    put_byte(acep_pkg::CH_ESC);
    put_byte(acep_pkg::CH_ESC);
    put_str("[mZ");
    send_text(EOT_NONE);
    put_byte(acep_pkg::CH_ESC);
    put_str("Z");
    send_text(EOT_NONE);
  endtask

  // End of text flushes a pending ESC, both alone and ahead of another byte,
  // and drops the open token of an unfinished sequence while the token that
  // a ';' already closed stays applied.
  task automatic test_end_of_text();
    put_byte(acep_pkg::CH_ESC);
    send_text(EOT_LAST);
    put_byte(acep_pkg::CH_ESC);
    put_str("q");
    send_text(EOT_LAST);
    put_byte(acep_pkg::CH_ESC);
    put_str("[34;4");
    send_text(EOT_LAST);
  endtask

  // Fifteen body bytes cut the sequence off. The body ends in a token made of
  // whitespace only, which the swallowed byte closes as a reset; the 'm'
  // after it is back in plain text.
  task automatic test_cutoff();
    put_byte(acep_pkg::CH_ESC);
    put_str("[32;");
    repeat (12) put_byte(acep_pkg::CH_SPACE);
    put_str(";m");
    send_text(EOT_NONE);
  endtask

  // --------------------------------------------------------------------------
  // Random tests.
  // --------------------------------------------------------------------------
  function automatic int pick_code();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return acep_pkg::CODE_FG_DARK + $urandom_range(0, 7);
      2:       return acep_pkg::CODE_BG_DARK + $urandom_range(0, 7);
      3:       return acep_pkg::CODE_FG_BRIGHT + $urandom_range(0, 7);
      4:       return acep_pkg::CODE_BG_BRIGHT + $urandom_range(0, 7);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // One token of a color sequence, mostly real codes, with whitespace,
  // signs, junk and empty tokens mixed in.
  task automatic add_random_token();
    logic [7:0] junk;
    case ($urandom_range(0, 9))
      0: begin
        // Empty token.
      end
      1, 2, 3, 4: begin
        put_number(pick_code(), $urandom_range(0, 7) == 0);
      end
      5: begin
        put_number($urandom_range(0, 999), $urandom_range(0, 3) == 0);
      end
      6: begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0:       put_byte(acep_pkg::CH_SPACE);
            1:       put_byte(acep_pkg::CH_TAB);
            2:       put_byte(acep_pkg::CH_CR);
            default: put_byte(8'h0B);
          endcase
        end
        case ($urandom_range(0, 2))
          0:       put_byte(acep_pkg::CH_PLUS);
          1:       put_byte(acep_pkg::CH_MINUS);
          default: ;
        endcase
        put_number(pick_code(), 1'b0);
      end
      7: begin
        // A sign or whitespace with no digits reads as zero.
        put_byte($urandom_range(0, 1) ? acep_pkg::CH_MINUS : acep_pkg::CH_SPACE);
      end
      8: begin
        // Digits stop at the first non-digit; later digits do not count.
        put_number(pick_code(), 1'b0);
        put_str("x");
        if ($urandom_range(0, 1)) begin
          put_number($urandom_range(0, 9), 1'b0);
        end
      end
      default: begin
        junk = 8'($urandom_range(0, 255));
        put_byte(junk);
      end
    endcase
  endtask

  // Mostly well-formed color sequences with random tokens; the rest is plain
  // text, lone escapes and sequences of random bytes. Idling is switched on
  // and off now and then so that some stretches run back to back.
  task automatic test_random_text(input int target);
    int first;
    int shape;
    int ntok;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      if ($urandom_range(0, 19) == 0) begin
        idle_en = !idle_en;
      end
      shape = $urandom_range(0, 19);
      if (shape < 11) begin
        put_byte(acep_pkg::CH_ESC);
        put_byte(acep_pkg::CH_LBRACKET);
        ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        for (int t = 0; t < ntok; t++) begin
          if (t > 0) begin
            put_byte(acep_pkg::CH_SEMI);
          end
          add_random_token();
        end
        put_byte(acep_pkg::CH_M);
      end else if (shape < 16) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 2) == 0) begin
            put_byte(8'($urandom_range(32, 126)));
          end else begin
            put_byte(8'($urandom_range(0, 255)));
          end
        end
      end else if (shape < 18) begin
        put_byte(acep_pkg::CH_ESC);
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_byte(acep_pkg::CH_ESC);
        put_byte(acep_pkg::CH_LBRACKET);
        repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
      end
      send_text(EOT_RANDOM);
    end
    idle_en = 1'b1;
  endtask

  // The receiver stops for a long stretch while bytes keep coming back to
  // back, so the result queue fills and the parser has to stall its input.
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (40) put_byte(8'($urandom_range(32, 126)));
    put_byte(acep_pkg::CH_ESC);
    put_str("[31;44;0;92;101m");
    send_text(EOT_NONE);
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_bytes();
    test_color_tokens();
    test_lone_escape();
    test_end_of_text();
    test_cutoff();
    test_random_text(1130);
    wait_drain();
    test_backpressure();
    wait_drain();
    $display("Sent %0d text bytes and checked %0d results, %0d of them color events.",
             bytes_sent, results_checked, color_events);
    $display("Covered lone escapes, cut-off and unterminated sequences, and a long stall.");
    if (mismatches == 0) begin
      $display("PASS ansi_color_escape_parser");
    end else begin
      $display("FAIL ansi_color_escape_parser");
    end
    $finish;
  end

endmodule

[sim.f]
src/acep_pkg.sv
src/acep_step.sv
src/acep_fifo.sv
src/ansi_color_escape_parser.sv
verif/tb.sv
